// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DEPTH   = ROWS << COL_W;

    // port field widths
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int RROW_W  = 5;
    localparam int RCOL_W  = 7;
    localparam int CELL_W  = CHAR_W + ATTR_W;

    // character codes and reset attribute
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

    // operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // one result word
    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [RROW_W-1:0] cursor_row;
        logic [RCOL_W-1:0] cursor_col;
        logic              scrolled;
    } result_t;

    // screen memory write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } ram_wr_t;

    // logical row plus top-of-screen offset, folded into the ring of rows
    function automatic logic [ROW_W-1:0] ring_row(input logic [ROW_W-1:0] a,
                                                  input logic [ROW_W-1:0] b);
        logic [ROW_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (32'(sum) >= ROWS)
            sum = sum - (ROW_W+1)'(ROWS);
        return sum[ROW_W-1:0];
    endfunction

endpackage

// ===== rtl/tcw_in_if.sv =====
`timescale 1ns / 1ps

interface tcw_in_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;

    modport source (output valid, output operation, output char_code,
                    output read_row, output read_col, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input read_row, input read_col, output ready);
endinterface

// ===== rtl/tcw_out_if.sv =====
`timescale 1ns / 1ps

interface tcw_out_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [RROW_W-1:0] cursor_row;
    logic [RCOL_W-1:0] cursor_col;
    logic              scrolled;

    modport source (output valid, output cell_char, output cell_attr,
                    output cursor_row, output cursor_col, output scrolled,
                    input ready);
    modport sink   (input valid, input cell_char, input cell_attr,
                    input cursor_row, input cursor_col, input scrolled,
                    output ready);
endinterface

// ===== rtl/tcw_screen_ram.sv =====
`timescale 1ns / 1ps

module tcw_screen_ram (
    input  logic                          clk,
    input  tcw_pkg::ram_wr_t              wr,
    input  logic                          rd_en,
    input  logic [tcw_pkg::ADDR_W-1:0]    rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]    rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/text_console_writer.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake     word
// in_ch     in   valid/ready   operation, char_code, read_row, read_col
// out_ch    out  valid/ready   cell_char, cell_attr, cursor_row, cursor_col, scrolled
// cfg       in   cfg_we        cfg_wdata -> text attribute
//
// a put is finished as it is accepted, a read after one registered memory read
// a put that scrolls also blanks the new bottom row before reporting; rows
// live in a ring, so a scroll moves the top pointer instead of copying
// after reset the block sweeps the whole screen before in_ch goes ready;
// cfg writes are taken meanwhile
// one result waits in the output register; while it stalls the next item
// is taken and finished, then parked until the output frees up

module text_console_writer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata,
    tcw_in_if.sink                      in_ch,
    tcw_out_if.source                   out_ch
);
    import tcw_pkg::*;

    // sequencer states
    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,  // reset sweep of the whole screen
        S_IDLE = 5'b00010,  // ready for a word
        S_RD   = 5'b00100,  // memory read data returns
        S_SCR  = 5'b01000,  // blanking the row that became the bottom row
        S_HOLD = 5'b10000   // finished result parked behind a stalled output
    } state_t;

    state_t            state_reg,   state_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  top_reg,     top_next;     // physical row shown first
    logic [ROW_W-1:0]  clr_row_reg, clr_row_next;
    logic [COL_W-1:0]  clr_col_reg, clr_col_next;
    logic [ATTR_W-1:0] attr_reg;
    logic              rd_ok_reg,   rd_ok_next;   // read address on screen
    result_t           pend_reg,    pend_next;
    result_t           out_reg,     out_next;
    logic              out_valid_reg, out_valid_next;

    ram_wr_t           ram_wr;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    logic              accept;
    logic              out_free;
    logic              done;
    result_t           done_res;

    // put path
    logic              is_nl;
    logic              wrap;
    logic              row_over;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;
    logic              clr_last_col;

    tcw_screen_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // cursor step of a put
    assign is_nl    = (in_ch.char_code == NEWLINE_CODE);
    assign wrap     = is_nl || (32'(cur_col_reg) == COLUMNS - 1);
    assign row_over = wrap && (32'(cur_row_reg) == ROWS - 1);
    assign put_col  = wrap ? '0 : cur_col_reg + COL_W'(1);
    assign put_row  = row_over ? ROW_W'(ROWS - 1)
                    : (wrap ? cur_row_reg + ROW_W'(1) : cur_row_reg);

    assign clr_last_col = (32'(clr_col_reg) == COLUMNS - 1);

    // read address is formed from the raw fields; out-of-range reads are
    // answered with zeros, so the address they produce does not matter
    assign ram_rd_en   = accept && (in_ch.operation == OP_READ);
    assign ram_rd_addr = {ring_row(ROW_W'(in_ch.read_row), top_reg),
                          COL_W'(in_ch.read_col)};

    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        clr_row_next   = clr_row_reg;
        clr_col_next   = clr_col_reg;
        rd_ok_next     = rd_ok_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        ram_wr         = '0;
        done           = 1'b0;
        done_res       = pend_reg;

        case (state_reg)
            S_CLR:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = {clr_row_reg, clr_col_reg};
                ram_wr.data = {RESET_ATTR, BLANK_CODE};
                if (clr_last_col)
                begin
                    clr_col_next = '0;
                    clr_row_next = clr_row_reg + ROW_W'(1);
                    if (32'(clr_row_reg) == ROWS - 1)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    clr_col_next = clr_col_reg + COL_W'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.operation == OP_READ)
                    begin
                        rd_ok_next = (32'(in_ch.read_row) < ROWS)
                                  && (32'(in_ch.read_col) < COLUMNS);
                        pend_next.cell_char  = '0;
                        pend_next.cell_attr  = '0;
                        pend_next.cursor_row = RROW_W'(cur_row_reg);
                        pend_next.cursor_col = RCOL_W'(cur_col_reg);
                        pend_next.scrolled   = 1'b0;
                        state_next = S_RD;
                    end
                    else
                    begin
                        // store at the cursor before it moves
                        ram_wr.en   = !is_nl;
                        ram_wr.addr = {ring_row(cur_row_reg, top_reg), cur_col_reg};
                        ram_wr.data = {attr_reg, in_ch.char_code};
                        cur_row_next = put_row;
                        cur_col_next = put_col;
                        done_res.cell_char  = '0;
                        done_res.cell_attr  = '0;
                        done_res.cursor_row = RROW_W'(put_row);
                        done_res.cursor_col = RCOL_W'(put_col);
                        done_res.scrolled   = row_over;
                        if (row_over)
                        begin
                            // old top row becomes the new bottom row
                            top_next     = ring_row(top_reg, ROW_W'(1));
                            clr_row_next = top_reg;
                            clr_col_next = '0;
                            pend_next    = done_res;
                            state_next   = S_SCR;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                end
            end

            S_RD:
            begin
                done = 1'b1;
                if (rd_ok_reg)
                begin
                    done_res.cell_char = ram_rd_data[CHAR_W-1:0];
                    done_res.cell_attr = ram_rd_data[CELL_W-1:CHAR_W];
                end
            end

            S_SCR:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = {clr_row_reg, clr_col_reg};
                ram_wr.data = {attr_reg, BLANK_CODE};
                clr_col_next = clr_col_reg + COL_W'(1);
                if (clr_last_col)
                begin
                    done = 1'b1;
                end
            end

            S_HOLD:
            begin
                done = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the finished result to the output, or park it
        if (done)
        begin
            if (out_free)
            begin
                out_next       = done_res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_next  = done_res;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            top_reg       <= '0;
            clr_row_reg   <= '0;
            clr_col_reg   <= '0;
            attr_reg      <= RESET_ATTR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            clr_row_reg   <= clr_row_next;
            clr_col_reg   <= clr_col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_ok_reg <= rd_ok_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.cell_char  = out_reg.cell_char;
    assign out_ch.cell_attr  = out_reg.cell_attr;
    assign out_ch.cursor_row = out_reg.cursor_row;
    assign out_ch.cursor_col = out_reg.cursor_col;
    assign out_ch.scrolled   = out_reg.scrolled;

    // cursor stays on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_row_reg) < ROWS) && (32'(cur_col_reg) < COLUMNS))
        else $error("cursor left the screen");

    // ring pointer stays within the rows
    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(top_reg) < ROWS)
        else $error("top row pointer out of range");

    // an accepted read enters the memory wait state S_RD in the following cycle
    a_read_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.operation == OP_READ) |=> (state_reg == S_RD))
        else $error("read did not enter memory wait");

    // a scroll blanks the bottom row before reporting
    a_scroll_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.operation == OP_PUT && row_over) |=> (state_reg == S_SCR))
        else $error("scroll did not start row blanking");

endmodule

// ===== bench/text_console_writer_test.sv =====
`timescale 1ns / 1ps

module text_console_writer_test;
    import tcw_pkg::*;

    // long receiver hold-off, settle time and run limit, in clock cycles
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 200;
    localparam int CYCLE_LIMIT = 400000;

    // one input word as the bench builds it
    typedef struct packed {
        logic              operation;
        logic [CHAR_W-1:0] char_code;
        logic [RROW_W-1:0] read_row;
        logic [RCOL_W-1:0] read_col;
    } console_word_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [ATTR_W-1:0]   cfg_wdata;

    tcw_in_if  in_ch ();
    tcw_out_if out_ch ();

    text_console_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // words waiting for the driver, results waiting for the monitor
    console_word_t pending_words[$];
    result_t       expected_results[$];

    // mirror of the screen, cursor and attribute register
    logic [CHAR_W-1:0] mirror_char [ROWS][COLUMNS];
    logic [ATTR_W-1:0] mirror_attr [ROWS][COLUMNS];
    int                mirror_row;
    int                mirror_col;
    logic [ATTR_W-1:0] attr_mirror;

    // idle rates in percent, set per phase
    int tx_idle_pct;
    int rx_idle_pct;

    // long hold requests, served by the receiver process
    int hold_requests;
    int holds_served;
    int hold_left;

    int  failures;
    int  cycle_count;
    bit  in_taken;

    // clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // update the mirror with one accepted word and return the result it causes
    function automatic result_t apply_console_word(input console_word_t w);
        result_t r;
        r = '0;
        if (w.operation == OP_READ)
        begin
            // out-of-range reads return zero bytes, nothing changes
            if (w.read_row < ROWS && w.read_col < COLUMNS)
            begin
                r.cell_char = mirror_char[w.read_row][w.read_col];
                r.cell_attr = mirror_attr[w.read_row][w.read_col];
            end
        end
        else
        begin
            if (w.char_code == NEWLINE_CODE)
            begin
                mirror_col = 0;
                mirror_row++;
            end
            else
            begin
                // control codes other than newline are stored like any other byte
                mirror_char[mirror_row][mirror_col] = w.char_code;
                mirror_attr[mirror_row][mirror_col] = attr_mirror;
                mirror_col++;
                if (mirror_col >= COLUMNS)
                begin
                    mirror_col = 0;
                    mirror_row++;
                end
            end
            if (mirror_row >= ROWS)
            begin
                // move every row up one, blank the bottom row
                for (int rr = 0; rr < ROWS - 1; rr++)
                    for (int cc = 0; cc < COLUMNS; cc++)
                    begin
                        mirror_char[rr][cc] = mirror_char[rr+1][cc];
                        mirror_attr[rr][cc] = mirror_attr[rr+1][cc];
                    end
                for (int cc = 0; cc < COLUMNS; cc++)
                begin
                    mirror_char[ROWS-1][cc] = BLANK_CODE;
                    mirror_attr[ROWS-1][cc] = attr_mirror;
                end
                mirror_row = ROWS - 1;
                r.scrolled = 1'b1;
            end
        end
        r.cursor_row = RROW_W'(mirror_row);
        r.cursor_col = RCOL_W'(mirror_col);
        return r;
    endfunction

    function automatic console_word_t put_word(input logic [CHAR_W-1:0] ch);
        console_word_t w;
        w.operation = OP_PUT;
        w.char_code = ch;
        // row and column are ignored on a put, keep them random
        w.read_row  = RROW_W'($urandom);
        w.read_col  = RCOL_W'($urandom);
        return w;
    endfunction

    function automatic console_word_t read_word(input int row, input int col);
        console_word_t w;
        w.operation = OP_READ;
        w.char_code = CHAR_W'($urandom);
        w.read_row  = RROW_W'(row);
        w.read_col  = RCOL_W'(col);
        return w;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s expected %0d actual %0d", name, exp_val, act_val);
            failures++;
        end
    endtask

    // queue random words: mostly puts with occasional newlines, reads biased
    // toward the bottom rows where fresh text lands
    task automatic queue_random_words(input int count, input int newline_pct);
        int kind;
        int row;
        int col;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 62)
            begin
                if ($urandom_range(0, 99) < newline_pct)
                    pending_words.push_back(put_word(NEWLINE_CODE));
                else
                    pending_words.push_back(put_word(CHAR_W'($urandom)));
            end
            else
            begin
                kind = $urandom_range(0, 9);
                col  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 30)
                                                   : $urandom_range(0, COLUMNS - 1);
                if (kind < 4)
                    row = $urandom_range(ROWS - 5, ROWS - 1);
                else if (kind < 8)
                    row = $urandom_range(0, ROWS - 1);
                else
                begin
                    // full field range, out-of-range cells included
                    row = $urandom_range(0, (1 << RROW_W) - 1);
                    col = $urandom_range(0, (1 << RCOL_W) - 1);
                end
                pending_words.push_back(read_word(row, col));
            end
        end
    endtask

    // wait until every queued word is taken and every result has come back
    task automatic drain_all();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0);
    endtask

    // register write only while idle; a scroll may still be blanking a row
    task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
        drain_all();
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        attr_mirror = value;
    endtask

    // one random phase: first half, sender pause until drained, second half
    task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
                             input int newline_pct, input bit long_hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (long_hold)
            hold_requests++;
        queue_random_words(count / 2, newline_pct);
        drain_all();
        queue_random_words(count - count / 2, newline_pct);
    endtask

    // sequencer: reset, directed words, then random phases over several attributes
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = RESET_ATTR;
        in_ch.valid      = 1'b0;
        in_ch.operation  = OP_PUT;
        in_ch.char_code  = '0;
        in_ch.read_row   = '0;
        in_ch.read_col   = '0;
        out_ch.ready     = 1'b0;
        failures         = 0;
        hold_requests    = 0;
        tx_idle_pct      = 17;
        rx_idle_pct      = 66;
        attr_mirror      = RESET_ATTR;
        mirror_row       = 0;
        mirror_col       = 0;
        for (int rr = 0; rr < ROWS; rr++)
            for (int cc = 0; cc < COLUMNS; cc++)
            begin
                mirror_char[rr][cc] = BLANK_CODE;
                mirror_attr[rr][cc] = RESET_ATTR;
            end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed: screen corners, out-of-range reads, byte extremes,
        // control codes, newline
        pending_words.push_back(read_word(0, 0));
        pending_words.push_back(read_word(ROWS - 1, COLUMNS - 1));
        pending_words.push_back(read_word(ROWS, 0));
        pending_words.push_back(read_word(0, COLUMNS));
        pending_words.push_back(read_word(31, 127));
        pending_words.push_back(put_word(8'h00));
        pending_words.push_back(put_word(8'hff));
        pending_words.push_back(put_word(8'h09));
        pending_words.push_back(put_word(NEWLINE_CODE));
        pending_words.push_back(put_word(8'h0d));
        pending_words.push_back(put_word(BLANK_CODE));
        pending_words.push_back(put_word(8'h41));
        pending_words.push_back(read_word(0, 0));
        pending_words.push_back(read_word(0, 1));
        pending_words.push_back(read_word(0, 2));
        pending_words.push_back(read_word(0, 3));
        pending_words.push_back(read_word(1, 0));
        pending_words.push_back(put_word(NEWLINE_CODE));
        pending_words.push_back(put_word(NEWLINE_CODE));
        pending_words.push_back(put_word(8'h7f));
        pending_words.push_back(read_word(3, 0));
        pending_words.push_back(read_word(1, 2));
        pending_words.push_back(read_word(ROWS - 1, 0));
        pending_words.push_back(put_word(8'h80));
        pending_words.push_back(read_word(3, 1));

        // reset attribute, sender idles lightly, receiver heavily
        run_phase(17, 66, 175, 5, 1'b0);
        // attribute extremes, idle rates swapped, then no idling with a long hold
        write_text_attribute(8'h00);
        run_phase(66, 17, 175, 2, 1'b0);
        write_text_attribute(8'hff);
        run_phase(0, 0, 175, 10, 1'b1);
        write_text_attribute(ATTR_W'($urandom));
        run_phase(17, 66, 175, 4, 1'b0);
        write_text_attribute(ATTR_W'($urandom));
        run_phase(66, 17, 175, 8, 1'b0);
        write_text_attribute(RESET_ATTR);
        run_phase(0, 0, 175, 3, 1'b1);

        drain_all();
        repeat (SETTLE) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            failures++;
        end
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // driver: new word only when the slot is empty or the last word was taken
    always @(negedge clk)
    begin : drive_input
        console_word_t w;
        if (!in_ch.valid || in_taken)
        begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                w = pending_words.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.operation <= w.operation;
                in_ch.char_code <= w.char_code;
                in_ch.read_row  <= w.read_row;
                in_ch.read_col  <= w.read_col;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a counted long hold-off on request
    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial
    begin
        holds_served = 0;
        hold_left    = 0;
    end

    // monitor: predict on each taken word, check each result against the oldest
    always @(posedge clk)
    begin : watch_ports
        result_t exp_r;
        in_taken = in_ch.valid && in_ch.ready;
        if (in_taken)
            expected_results.push_back(apply_console_word({in_ch.operation, in_ch.char_code,
                                                           in_ch.read_row, in_ch.read_col}));
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no word waiting for it");
                failures++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("cell_char", exp_r.cell_char, out_ch.cell_char);
                check_field("cell_attr", exp_r.cell_attr, out_ch.cell_attr);
                check_field("cursor_row", exp_r.cursor_row, out_ch.cursor_row);
                check_field("cursor_col", exp_r.cursor_col, out_ch.cursor_col);
                check_field("scrolled", exp_r.scrolled, out_ch.scrolled);
            end
        end
    end

    // run limit
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// ===== text_console_writer.f =====
rtl/tcw_pkg.sv
rtl/tcw_in_if.sv
rtl/tcw_out_if.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer.sv
bench/text_console_writer_test.sv
